// ===== rtl/jdm_pkg.sv =====
// joystick drive mixer package: sizes, scale constants and register codes
// used by joystick_drive_mixer_top; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package jdm_pkg;

	localparam int AVERAGE_DEPTH = 5;
	localparam int SAMPLE_BITS   = 12;

	localparam int ADC_MAX = (1 << SAMPLE_BITS) - 1;
	localparam int SLOT_W  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

	localparam int CENT_W = SAMPLE_BITS + 1;
	localparam int SUM_W  = CENT_W + $clog2(AVERAGE_DEPTH + 1);
	localparam int D_W    = SUM_W + 1;
	localparam int BAND_W = 16;
	localparam int GAIN_W = 7;
	localparam int AX_W   = ((D_W > BAND_W) ? D_W : BAND_W) + 1;
	localparam int MIX_W  = AX_W + 1;
	localparam int PROD_W = MIX_W + GAIN_W + 1;

	localparam int DRIVE_LIMIT  = 90;
	localparam int DRIVE_OFFSET = 90;
	localparam int CMD_W        = 8;

	localparam longint FULL_SCALE  = 2 * AVERAGE_DEPTH * ADC_MAX;
	localparam longint SAT_LIMIT   = (DRIVE_LIMIT + 1) * FULL_SCALE;
	localparam int     MAG_W       = $clog2(SAT_LIMIT);
	localparam int     FULL_LOG    = $clog2(FULL_SCALE);
	localparam int     RECIP_SHIFT = MAG_W + FULL_LOG;
	localparam longint RECIP_MULT  = ((64'd1 << RECIP_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
	localparam int     Q_W         = $clog2(DRIVE_LIMIT + 1);
	localparam int     QPROD_W     = RECIP_SHIFT + Q_W;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int DEADBAND_RESET = 4095;
	localparam int GAIN_RESET     = 60;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MIRROR_MODE    = 2'd0,
		CFG_DEADBAND_WIDTH = 2'd1,
		CFG_SPEED_GAIN     = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic signed [CENT_W-1:0] horizontal;
		logic signed [CENT_W-1:0] vertical;
	} hist_entry_t;

endpackage

`default_nettype wire

// ===== rtl/joystick_drive_mixer_top.sv =====
// joystick drive mixer top level: ring memory, running sums, deadband,
// differential mix and scaling pipeline; depends on jdm_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one joystick request per clock while in_ready is high (a stall on the
// output side holds it) and returns one drive command pair per request, in order.
// The five-deep history of both axes sits in a small synchronous memory; each
// request reads the oldest entry, updates running sums and writes its own
// centred sample back, so the memory's single read and write port sets the
// rate of one request per cycle. Reset clears the history through per-entry
// valid bits, so no clearing pass is needed and requests are taken at once.
// The scale by full range uses a reciprocal multiply, exact for every input.
// The user writes configuration through the cfg channel only while the block is idle; the block does not enforce this.
module joystick_drive_mixer_top (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [jdm_pkg::SAMPLE_BITS-1:0] horizontal_sample,
	input  wire  [jdm_pkg::SAMPLE_BITS-1:0] vertical_sample,
	input  wire                             button_pressed,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [jdm_pkg::CMD_W-1:0]       left_command,
	output logic [jdm_pkg::CMD_W-1:0]       right_command,
	output logic                            button_flag,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [jdm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire  [jdm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CENT_W = jdm_pkg::CENT_W;
	localparam int SUM_W  = jdm_pkg::SUM_W;
	localparam int AX_W   = jdm_pkg::AX_W;
	localparam int MIX_W  = jdm_pkg::MIX_W;
	localparam int PROD_W = jdm_pkg::PROD_W;
	localparam int MAG_W  = jdm_pkg::MAG_W;
	localparam int Q_W    = jdm_pkg::Q_W;
	localparam int DEPTH  = jdm_pkg::AVERAGE_DEPTH;
	localparam int SLOT_W = jdm_pkg::SLOT_W;

	// configuration registers
	logic                          mirror_q;
	logic [jdm_pkg::BAND_W-1:0]    band_q;
	logic [jdm_pkg::GAIN_W-1:0]    gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
			band_q   <= jdm_pkg::BAND_W'(jdm_pkg::DEADBAND_RESET);
			gain_q   <= jdm_pkg::GAIN_W'(jdm_pkg::GAIN_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				jdm_pkg::CFG_MIRROR_MODE:    mirror_q <= cfg_data[0];
				jdm_pkg::CFG_DEADBAND_WIDTH: band_q   <= cfg_data[jdm_pkg::BAND_W-1:0];
				jdm_pkg::CFG_SPEED_GAIN:     gain_q   <= cfg_data[jdm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, out_valid_q;
	logic en_out, en_s5, en_s4, en_s3, en_s2, en_s1, accept;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s5    = !valid_s5 || en_out;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign accept   = in_valid && en_s1;

	// centring
	jdm_pkg::hist_entry_t cent_in;
	assign cent_in.horizontal = CENT_W'(jdm_pkg::ADC_MAX) - {horizontal_sample, 1'b0};
	assign cent_in.vertical   = CENT_W'(jdm_pkg::ADC_MAX) - {vertical_sample, 1'b0};

	// history memory and slot pointer
	jdm_pkg::hist_entry_t mem [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	logic [SLOT_W-1:0]    slot_q;
	jdm_pkg::hist_entry_t rd_s1, fwd_s1, cent_s1;
	logic                 hit_s1, fwd_hit_s1, btn_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic                 wr_en;

	assign wr_en = valid_s1 && en_s2;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[slot_q];
		end
		if (wr_en) begin
			mem[slot_s1] <= cent_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			slot_q     <= '0;
			valid_s1   <= 1'b0;
			hit_s1     <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[slot_s1] <= 1'b1;
			end
			if (accept) begin
				slot_q     <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
				hit_s1     <= vld_q[slot_q];
				fwd_hit_s1 <= valid_s1 && (slot_s1 == slot_q);
			end
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cent_s1 <= cent_in;
			fwd_s1  <= cent_s1;
			slot_s1 <= slot_q;
			btn_s1  <= button_pressed;
		end
	end

	// running sums
	jdm_pkg::hist_entry_t     old_s1;
	logic signed [SUM_W-1:0]  sum_h_q, sum_v_q, sum_h_new, sum_v_new;

	always_comb begin
		if (fwd_hit_s1) begin
			old_s1 = fwd_s1;
		end else if (hit_s1) begin
			old_s1 = rd_s1;
		end else begin
			old_s1 = '0;
		end
		sum_h_new = sum_h_q + SUM_W'(cent_s1.horizontal) - SUM_W'(old_s1.horizontal);
		sum_v_new = sum_v_q + SUM_W'(cent_s1.vertical) - SUM_W'(old_s1.vertical);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_h_q <= '0;
			sum_v_q <= '0;
		end else if (wr_en) begin
			sum_h_q <= sum_h_new;
			sum_v_q <= sum_v_new;
		end
	end

	// stage 2: deadband and mirror
	logic signed [SUM_W-1:0] sum_h_s2, sum_v_s2;
	logic                    btn_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sum_h_s2 <= sum_h_new;
			sum_v_s2 <= sum_v_new;
			btn_s2   <= btn_s1;
		end
	end

	function automatic logic signed [AX_W-1:0] apply_band(
		input logic signed [SUM_W-1:0]          sum,
		input logic [jdm_pkg::BAND_W-1:0]       band,
		input logic                             mirror
	);
		logic signed [AX_W-1:0] d;
		logic signed [AX_W-1:0] b;
		logic signed [AX_W-1:0] r;
		d = AX_W'(sum) <<< 1;
		b = AX_W'({1'b0, band});
		if (d < b && d > -b) begin
			r = '0;
		end else if (d > 0) begin
			r = d - b;
		end else begin
			r = d + b;
		end
		return mirror ? -r : r;
	endfunction

	logic signed [AX_W-1:0] h_s3, v_s3;
	logic                   btn_s3;

	always_ff @(posedge clk) begin
		if (valid_s2 && en_s3) begin
			h_s3   <= apply_band(sum_h_s2, band_q, mirror_q);
			v_s3   <= apply_band(sum_v_s2, band_q, mirror_q);
			btn_s3 <= btn_s2;
		end
	end

	// stage 3: mix and gain
	logic signed [PROD_W-1:0] gain_ext, mix_l, mix_r;
	logic signed [PROD_W-1:0] prod_l_s4, prod_r_s4;
	logic                     btn_s4;

	assign gain_ext = PROD_W'({1'b0, gain_q});
	assign mix_l    = PROD_W'(MIX_W'(v_s3) + MIX_W'(h_s3));
	assign mix_r    = PROD_W'(MIX_W'(h_s3) - MIX_W'(v_s3));

	always_ff @(posedge clk) begin
		if (valid_s3 && en_s4) begin
			prod_l_s4 <= mix_l * gain_ext;
			prod_r_s4 <= mix_r * gain_ext;
			btn_s4    <= btn_s3;
		end
	end

	// stage 4: magnitude and saturation
	logic [PROD_W-1:0] abs_l, abs_r;
	logic [MAG_W-1:0]  mag_l_s5, mag_r_s5;
	logic              sat_l_s5, sat_r_s5, neg_l_s5, neg_r_s5, btn_s5;

	assign abs_l = prod_l_s4[PROD_W-1] ? PROD_W'(-prod_l_s4) : PROD_W'(prod_l_s4);
	assign abs_r = prod_r_s4[PROD_W-1] ? PROD_W'(-prod_r_s4) : PROD_W'(prod_r_s4);

	always_ff @(posedge clk) begin
		if (valid_s4 && en_s5) begin
			mag_l_s5 <= abs_l[MAG_W-1:0];
			mag_r_s5 <= abs_r[MAG_W-1:0];
			sat_l_s5 <= abs_l >= PROD_W'(jdm_pkg::SAT_LIMIT);
			sat_r_s5 <= abs_r >= PROD_W'(jdm_pkg::SAT_LIMIT);
			neg_l_s5 <= prod_l_s4[PROD_W-1];
			neg_r_s5 <= prod_r_s4[PROD_W-1];
			btn_s5   <= btn_s4;
		end
	end

	// stage 5: reciprocal scale and offset
	logic [jdm_pkg::QPROD_W-1:0] qprod_l, qprod_r;
	logic [Q_W-1:0]              q_l, q_r;

	assign qprod_l = jdm_pkg::QPROD_W'(mag_l_s5) * jdm_pkg::QPROD_W'(jdm_pkg::RECIP_MULT);
	assign qprod_r = jdm_pkg::QPROD_W'(mag_r_s5) * jdm_pkg::QPROD_W'(jdm_pkg::RECIP_MULT);
	assign q_l = sat_l_s5 ? Q_W'(jdm_pkg::DRIVE_LIMIT) : qprod_l[jdm_pkg::RECIP_SHIFT +: Q_W];
	assign q_r = sat_r_s5 ? Q_W'(jdm_pkg::DRIVE_LIMIT) : qprod_r[jdm_pkg::RECIP_SHIFT +: Q_W];

	function automatic logic [jdm_pkg::CMD_W-1:0] to_command(
		input logic [Q_W-1:0] q,
		input logic           neg
	);
		logic [jdm_pkg::CMD_W-1:0] base;
		base = jdm_pkg::CMD_W'(jdm_pkg::DRIVE_OFFSET);
		return neg ? base - jdm_pkg::CMD_W'(q) : base + jdm_pkg::CMD_W'(q);
	endfunction

	always_ff @(posedge clk) begin
		if (valid_s5 && en_out) begin
			left_command  <= to_command(q_l, neg_l_s5);
			right_command <= to_command(q_r, neg_r_s5);
			button_flag   <= btn_s5;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
			if (en_s5) begin
				valid_s5 <= valid_s4;
			end
			if (en_out) begin
				out_valid_q <= valid_s5;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== tb/tb_joystick_drive_mixer_top.sv =====
// testbench for joystick_drive_mixer_top: directed and random joystick requests,
// checked against a cycle-free predictor of the filter, deadband and mix
// depends on jdm_pkg and joystick_drive_mixer_top
`timescale 1ns / 1ps

module tb_joystick_drive_mixer_top;

	localparam int     AVERAGE_DEPTH  = jdm_pkg::AVERAGE_DEPTH;
	localparam int     SAMPLE_BITS    = jdm_pkg::SAMPLE_BITS;
	localparam int     ADC_MAX        = jdm_pkg::ADC_MAX;
	localparam int     SLOT_W         = jdm_pkg::SLOT_W;
	localparam int     CENT_W         = jdm_pkg::CENT_W;
	localparam int     BAND_W         = jdm_pkg::BAND_W;
	localparam int     GAIN_W         = jdm_pkg::GAIN_W;
	localparam int     DRIVE_LIMIT    = jdm_pkg::DRIVE_LIMIT;
	localparam int     DRIVE_OFFSET   = jdm_pkg::DRIVE_OFFSET;
	localparam int     CMD_W          = jdm_pkg::CMD_W;
	localparam int     CFG_INDEX_W    = jdm_pkg::CFG_INDEX_W;
	localparam int     CFG_DATA_W     = jdm_pkg::CFG_DATA_W;
	localparam int     DEADBAND_RESET = jdm_pkg::DEADBAND_RESET;
	localparam int     GAIN_RESET     = jdm_pkg::GAIN_RESET;
	localparam longint FULL_SCALE     = jdm_pkg::FULL_SCALE;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_GAP      = 50;
	localparam int REPORT_LIMIT = 10;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] left;
		logic [CMD_W-1:0] right;
		logic             button;
	} drive_cmd_t;

	logic                   clk;
	logic                   arst_n            = 1'b0;
	logic                   in_valid          = 1'b0;
	logic                   in_ready;
	logic [SAMPLE_BITS-1:0] horizontal_sample = '0;
	logic [SAMPLE_BITS-1:0] vertical_sample   = '0;
	logic                   button_pressed    = 1'b0;
	logic                   out_valid;
	logic                   out_ready         = 1'b0;
	logic [CMD_W-1:0]       left_command;
	logic [CMD_W-1:0]       right_command;
	logic                   button_flag;
	logic                   cfg_valid         = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index         = '0;
	logic [CFG_DATA_W-1:0]  cfg_data          = '0;

	joystick_drive_mixer_top i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.horizontal_sample (horizontal_sample),
		.vertical_sample   (vertical_sample),
		.button_pressed    (button_pressed),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.left_command      (left_command),
		.right_command     (right_command),
		.button_flag       (button_flag),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// predictor state
	logic signed [CENT_W-1:0] ring_h [AVERAGE_DEPTH];
	logic signed [CENT_W-1:0] ring_v [AVERAGE_DEPTH];
	logic [SLOT_W-1:0]        ring_slot;
	logic                     mirror_cfg;
	logic [BAND_W-1:0]        band_cfg;
	logic [GAIN_W-1:0]        gain_cfg;

	drive_cmd_t             pending_commands[$];
	int                     mismatches     = 0;
	int                     cycle_count    = 0;
	int                     send_idle_pct  = 0;
	int                     recv_stall_pct = 0;
	logic [SAMPLE_BITS-1:0] last_h         = '0;
	logic [SAMPLE_BITS-1:0] last_v         = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	function automatic longint apply_deadband(longint d, longint band);
		if (d < band && d > -band)
			return 0;
		return (d > 0) ? d - band : d + band;
	endfunction

	function automatic longint clamp_drive_level(longint x);
		if (x > DRIVE_LIMIT)
			return DRIVE_LIMIT;
		if (x < -DRIVE_LIMIT)
			return -DRIVE_LIMIT;
		return x;
	endfunction

	function automatic drive_cmd_t mix_drive_command(logic [SAMPLE_BITS-1:0] hs,
			logic [SAMPLE_BITS-1:0] vs, logic b);
		longint     sum_h, sum_v, h, v, band, gain, left, right;
		drive_cmd_t cmd;
		ring_h[ring_slot] = CENT_W'(ADC_MAX - 2 * int'(hs));
		ring_v[ring_slot] = CENT_W'(ADC_MAX - 2 * int'(vs));
		if (ring_slot == SLOT_W'(AVERAGE_DEPTH - 1))
			ring_slot = '0;
		else
			ring_slot = ring_slot + 1'b1;
		sum_h = 0;
		sum_v = 0;
		for (int i = 0; i < AVERAGE_DEPTH; i++) begin
			sum_h += ring_h[i];
			sum_v += ring_v[i];
		end
		band = longint'(band_cfg);
		gain = longint'(gain_cfg);
		h = apply_deadband(2 * sum_h, band);
		v = apply_deadband(2 * sum_v, band);
		if (mirror_cfg) begin
			h = -h;
			v = -v;
		end
		left  = clamp_drive_level((gain * (v + h)) / FULL_SCALE);
		right = clamp_drive_level((gain * (h - v)) / FULL_SCALE);
		cmd.left   = CMD_W'(left + DRIVE_OFFSET);
		cmd.right  = CMD_W'(right + DRIVE_OFFSET);
		cmd.button = b;
		return cmd;
	endfunction

	function automatic void note_mismatch(string what, drive_cmd_t want, drive_cmd_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch (%s) cycle %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
				what, cycle_count, want.left, want.right, want.button,
				got.left, got.right, got.button);
	endfunction

	// result checker
	always @(posedge clk) begin
		drive_cmd_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got = {left_command, right_command, button_flag};
			if (pending_commands.size() == 0) begin
				note_mismatch("unexpected", '0, got);
			end else begin
				want = pending_commands.pop_front();
				if (got.left !== want.left || got.right !== want.right ||
						got.button !== want.button)
					note_mismatch("field", want, got);
			end
		end
	end

	task automatic send_request(input logic [SAMPLE_BITS-1:0] hs,
			input logic [SAMPLE_BITS-1:0] vs, input logic b);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid          <= 1'b1;
		horizontal_sample <= hs;
		vertical_sample   <= vs;
		button_pressed    <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_commands.push_back(mix_drive_command(hs, vs, b));
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_commands.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			jdm_pkg::CFG_MIRROR_MODE:    mirror_cfg = data[0];
			jdm_pkg::CFG_DEADBAND_WIDTH: band_cfg   = data[BAND_W-1:0];
			jdm_pkg::CFG_SPEED_GAIN:     gain_cfg   = data[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] prev);
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 4)
			return prev;
		if (mode < 6)
			return $urandom_range(0, 1) ? SAMPLE_BITS'(ADC_MAX) : '0;
		if (mode < 8)
			return SAMPLE_BITS'($urandom_range(2040, 2055));
		return SAMPLE_BITS'($urandom_range(0, ADC_MAX));
	endfunction

	task automatic shuffle_config();
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		write_register(jdm_pkg::CFG_MIRROR_MODE, word);
		case ($urandom_range(0, 5))
			0: word = '0;
			1: word = CFG_DATA_W'(DEADBAND_RESET);
			2: word = CFG_DATA_W'(FULL_SCALE);
			3: word = '1;
			4: word = CFG_DATA_W'($urandom_range(0, 8000));
			default: word = CFG_DATA_W'($urandom);
		endcase
		write_register(jdm_pkg::CFG_DEADBAND_WIDTH, word);
		word = CFG_DATA_W'($urandom);
		case ($urandom_range(0, 5))
			0: word[GAIN_W-1:0] = '0;
			1: word[GAIN_W-1:0] = GAIN_W'(DRIVE_LIMIT);
			2: word[GAIN_W-1:0] = '1;
			3: word[GAIN_W-1:0] = GAIN_W'(GAIN_RESET);
			default: ;
		endcase
		write_register(jdm_pkg::CFG_SPEED_GAIN, word);
	endtask

	// opposite centred samples cancel in the ring at default settings
	task automatic test_reset_state();
		send_request(12'd2047, 12'd2048, 1'b0);
		send_request(12'd2048, 12'd2047, 1'b1);
	endtask

	// four entries summing to zero with no deadband
	task automatic test_zero_band();
		write_register(jdm_pkg::CFG_DEADBAND_WIDTH, '0);
		send_request(12'd2047, 12'd2048, 1'b1);
		send_request(12'd2048, 12'd2047, 1'b0);
	endtask

	task automatic test_field_extremes();
		send_request('0, '0, 1'b1);
		send_request(SAMPLE_BITS'(ADC_MAX), SAMPLE_BITS'(ADC_MAX), 1'b0);
		send_request('0, SAMPLE_BITS'(ADC_MAX), 1'b1);
		send_request(SAMPLE_BITS'(ADC_MAX), '0, 1'b0);
		send_request('0, '0, 1'b0);
		send_request('0, '0, 1'b1);
	endtask

	task automatic test_mirror();
		write_register(jdm_pkg::CFG_MIRROR_MODE, 16'h0001);
		send_request(SAMPLE_BITS'(ADC_MAX), '0, 1'b1);
		send_request('0, SAMPLE_BITS'(ADC_MAX), 1'b0);
		send_request(12'd2047, 12'd2048, 1'b1);
		write_register(jdm_pkg::CFG_MIRROR_MODE, 16'hFFFE);
	endtask

	task automatic test_wide_band();
		write_register(jdm_pkg::CFG_DEADBAND_WIDTH, CFG_DATA_W'(FULL_SCALE));
		send_request('0, '0, 1'b0);
		send_request(SAMPLE_BITS'(ADC_MAX), '0, 1'b1);
		write_register(jdm_pkg::CFG_DEADBAND_WIDTH, 16'hFFFF);
		send_request('0, '0, 1'b1);
	endtask

	task automatic test_gain_extremes();
		write_register(jdm_pkg::CFG_DEADBAND_WIDTH, '0);
		write_register(jdm_pkg::CFG_SPEED_GAIN, '0);
		send_request('0, SAMPLE_BITS'(ADC_MAX), 1'b1);
		write_register(jdm_pkg::CFG_SPEED_GAIN, 16'hFFFF);
		send_request('0, '0, 1'b0);
		send_request(SAMPLE_BITS'(ADC_MAX), '0, 1'b1);
		write_register(jdm_pkg::CFG_SPEED_GAIN, CFG_DATA_W'(DRIVE_LIMIT));
		send_request('0, '0, 1'b0);
	endtask

	// writes to the unused index change nothing
	task automatic test_spare_index();
		write_register(CFG_SPARE_INDEX, 16'hFFFF);
		send_request(SAMPLE_BITS'(ADC_MAX), SAMPLE_BITS'(ADC_MAX), 1'b1);
	endtask

	task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
		send_idle_pct  = sender_pct;
		recv_stall_pct = receiver_pct;
		for (int s = 0; s < 4; s++) begin
			shuffle_config();
			for (int n = 0; n < 100; n++) begin
				last_h = pick_sample(last_h);
				last_v = pick_sample(last_v);
				send_request(last_h, last_v, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < AVERAGE_DEPTH; i++) begin
			ring_h[i] = '0;
			ring_v[i] = '0;
		end
		ring_slot  = '0;
		mirror_cfg = 1'b0;
		band_cfg   = BAND_W'(DEADBAND_RESET);
		gain_cfg   = GAIN_W'(GAIN_RESET);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_zero_band();
		test_field_extremes();
		test_mirror();
		test_wide_band();
		test_gain_extremes();
		test_spare_index();

		test_random_traffic(0, 0);
		test_random_traffic(53, 0);
		test_random_traffic(0, 53);
		test_random_traffic(21, 21);

		in_valid <= 1'b0;
		while (pending_commands.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/jdm_pkg.sv
rtl/joystick_drive_mixer_top.sv
tb/tb_joystick_drive_mixer_top.sv
